/* src/bpc_pkg.sv */
// bpc_pkg: shared widths, constants, register indexes and divider stage types
// for the barometric temperature and pressure compensation block
// no dependencies
package bpc_pkg;

    // payload widths
    localparam int RAW_T_W  = 16;
    localparam int RAW_P_W  = 19;
    localparam int TEMP_W   = 12;
    localparam int PRESS_W  = 18;

    // configuration port
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 64;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_OVERSAMPLING = 2'd0;
    localparam reg_idx_t REG_COEF_A       = 2'd1;
    localparam reg_idx_t REG_COEF_B       = 2'd2;
    localparam reg_idx_t REG_COEF_C       = 2'd3;

    // iterations of the two restoring dividers
    localparam int TDIV_STEPS = 27;
    localparam int PDIV_STEPS = 32;

    // compensation constants
    localparam logic signed [31:0] TEMP_OFFSET = 32'sd4000;
    localparam logic signed [31:0] B4_BIAS     = 32'sd32768;
    localparam logic        [15:0] B7_SCALE    = 16'd50000;
    localparam logic signed [31:0] CORR_SQ     = 32'sd3038;
    localparam logic signed [31:0] CORR_LIN    = -32'sd7357;
    localparam logic signed [31:0] CORR_OFF    = 32'sd3791;
    localparam logic signed [31:0] TEMP_MIN    = -32'sd2048;
    localparam logic signed [31:0] TEMP_MAX    = 32'sd2047;
    localparam logic signed [31:0] PRESS_MAX   = 32'sd262143;

    // side data that rides along with an item once temperature is known
    typedef struct packed {
        logic signed [TEMP_W-1:0] t;
        logic                     err;
    } side_t;

    // one step of the temperature divider
    typedef struct packed {
        logic        [31:0]        rem;
        logic        [TDIV_STEPS-1:0] num;
        logic        [31:0]        den;
        logic                      neg;
        logic                      err;
        logic signed [31:0]        x1;
        logic        [RAW_P_W-1:0] up;
    } tdiv_t;

    // one step of the pressure divider
    typedef struct packed {
        logic [16:0]           rem;
        logic [PDIV_STEPS-1:0] num;
        logic [16:0]           den;
        logic                  hi;
        side_t                 side;
    } pdiv_t;

endpackage

/* src/bpc_if.sv */
// bpc_if: valid/ready channel interfaces for raw samples and compensated results
// depends on bpc_pkg
interface bpc_in_if;
    logic                          valid;
    logic                          ready;
    logic [bpc_pkg::RAW_T_W-1:0]   raw_temperature;
    logic [bpc_pkg::RAW_P_W-1:0]   raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bpc_pkg::TEMP_W-1:0]   temperature_tenths;
    logic        [bpc_pkg::PRESS_W-1:0]  pressure_pa;
    logic                                div_error;

    modport source (output valid, output temperature_tenths, output pressure_pa,
                    output div_error, input ready);
    modport sink   (input valid, input temperature_tenths, input pressure_pa,
                    input div_error, output ready);
endinterface

/* src/baro_temp_pressure_compensation.sv */
// baro_temp_pressure_compensation: pipelined integer compensation of raw
// barometric temperature and pressure readings
// depends on bpc_pkg and bpc_if
//
// Usage: calibration words and the oversampling setting are written over the
// APB port (64-bit registers at byte addresses 0, 8, 16, 24) while no
// transaction is in flight. Raw sample pairs enter on in_ch, one transaction
// per cycle while in_ch.ready is high; each produces one result transaction
// on out_ch: temperature in 0.1 degC, pressure in Pa and a divide-by-zero flag.
// A transaction passes, in order, through the input stage, which loads at
// the accepting edge, 28 stages of the temperature divider (setup plus one
// quotient bit each), eight arithmetic stages, 33 stages of the pressure
// divider and the output register. The bit-per-stage dividers set throughput:
// one transaction per cycle while the skid register is empty.
// Reset clears all valid bits and all configuration registers to zero.
// When out_ch stalls, the pipeline keeps moving until one more result lands
// in a skid register; then the whole pipeline holds and in_ch.ready drops
// until the skid drains.
module baro_temp_pressure_compensation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpc_pkg::APB_AW-1:0]    paddr,
    input  logic [bpc_pkg::APB_DW-1:0]    pwdata,
    output logic [bpc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    bpc_in_if.sink                        in_ch,
    bpc_out_if.source                     out_ch
);

    // configuration registers
    logic [1:0]  oss_reg;
    logic [63:0] coef_a_reg;
    logic [63:0] coef_b_reg;
    logic [31:0] coef_c_reg;
    bpc_pkg::reg_idx_t reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = bpc_pkg::reg_idx_t'(paddr[4:3]);

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg    <= '0;
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                bpc_pkg::REG_OVERSAMPLING: oss_reg    <= pwdata[1:0];
                bpc_pkg::REG_COEF_A:       coef_a_reg <= pwdata;
                bpc_pkg::REG_COEF_B:       coef_b_reg <= pwdata;
                bpc_pkg::REG_COEF_C:       coef_c_reg <= pwdata[31:0];
                default:                   oss_reg    <= oss_reg;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (reg_idx)
            bpc_pkg::REG_OVERSAMPLING: prdata = {62'd0, oss_reg};
            bpc_pkg::REG_COEF_A:       prdata = coef_a_reg;
            bpc_pkg::REG_COEF_B:       prdata = coef_b_reg;
            bpc_pkg::REG_COEF_C:       prdata = {32'd0, coef_c_reg};
            default:                   prdata = '0;
        endcase
    end

    // calibration fields
    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic        [15:0] ac4, ac5, ac6;
    assign ac1 = $signed(coef_a_reg[63:48]);
    assign ac2 = $signed(coef_a_reg[47:32]);
    assign ac3 = $signed(coef_a_reg[31:16]);
    assign ac4 = coef_a_reg[15:0];
    assign ac5 = coef_b_reg[63:48];
    assign ac6 = coef_b_reg[47:32];
    assign b1  = $signed(coef_b_reg[31:16]);
    assign b2  = $signed(coef_b_reg[15:0]);
    assign mc  = $signed(coef_c_reg[31:16]);
    assign md  = $signed(coef_c_reg[15:0]);

    // pipeline advances unless the skid register holds a result
    logic pipe_en;
    logic skid_v_reg;
    assign pipe_en     = ~skid_v_reg;
    assign in_ch.ready = pipe_en;

    // stage a: x1 of the temperature path
    logic signed [16:0] a_diff;
    logic signed [33:0] a_prod;
    logic signed [31:0] a_x1_next;
    logic               a_v_reg;
    logic signed [31:0] a_x1_reg;
    logic [bpc_pkg::RAW_P_W-1:0] a_up_reg;

    assign a_diff    = $signed({1'b0, in_ch.raw_temperature}) - $signed({1'b0, ac6});
    assign a_prod    = a_diff * $signed({1'b0, ac5});
    assign a_x1_next = $signed(a_prod[31:0]) >>> 15;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (pipe_en)
            a_v_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_x1_reg <= a_x1_next;
            a_up_reg <= in_ch.raw_pressure;
        end
    end

    // temperature divider setup: (mc * 2048) / (x1 + md), truncating
    logic signed [31:0] td_den_s;
    logic        [15:0] mc_abs;
    bpc_pkg::tdiv_t     td_first;

    assign td_den_s = a_x1_reg + 32'(md);
    assign mc_abs   = mc[15] ? 16'(-mc) : 16'(mc);

    always_comb
    begin
        td_first.rem = '0;
        td_first.num = {mc_abs, 11'd0};
        td_first.den = td_den_s[31] ? 32'(-td_den_s) : 32'(td_den_s);
        td_first.neg = mc[15] ^ td_den_s[31];
        td_first.err = (td_den_s == 32'sd0);
        td_first.x1  = a_x1_reg;
        td_first.up  = a_up_reg;
    end

    function automatic bpc_pkg::tdiv_t tdiv_step(input bpc_pkg::tdiv_t s);
        bpc_pkg::tdiv_t r;
        logic [32:0]    sh;
        logic           q;
        r  = s;
        sh = {s.rem, s.num[bpc_pkg::TDIV_STEPS-1]};
        q  = (sh >= {1'b0, s.den});
        r.rem = q ? 32'(sh - {1'b0, s.den}) : sh[31:0];
        r.num = {s.num[bpc_pkg::TDIV_STEPS-2:0], q};
        return r;
    endfunction

    bpc_pkg::tdiv_t                  td_reg [0:bpc_pkg::TDIV_STEPS];
    logic [bpc_pkg::TDIV_STEPS:0]    td_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            td_v_reg <= '0;
        else if (pipe_en)
            td_v_reg <= {td_v_reg[bpc_pkg::TDIV_STEPS-1:0], a_v_reg};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            td_reg[0] <= td_first;
    end

    for (genvar k = 0; k < bpc_pkg::TDIV_STEPS; k++)
    begin : g_tdiv
        always_ff @(posedge clk)
        begin
            if (pipe_en)
                td_reg[k+1] <= tdiv_step(td_reg[k]);
        end
    end

    // stage c: b5, temperature and b6
    bpc_pkg::tdiv_t     td_last;
    logic signed [31:0] c_x2, c_b5, c_t32;
    bpc_pkg::side_t     c_side_next;
    logic               c_v_reg;
    logic signed [31:0] c_b6_reg;
    bpc_pkg::side_t     c_side_reg;
    logic [bpc_pkg::RAW_P_W-1:0] c_up_reg;

    assign td_last = td_reg[bpc_pkg::TDIV_STEPS];
    assign c_x2    = td_last.neg ? -$signed(32'(td_last.num)) : $signed(32'(td_last.num));
    assign c_b5    = td_last.x1 + c_x2;
    assign c_t32   = (c_b5 + 32'sd8) >>> 4;

    always_comb
    begin
        if (c_t32 < bpc_pkg::TEMP_MIN)
            c_side_next.t = bpc_pkg::TEMP_MIN[bpc_pkg::TEMP_W-1:0];
        else if (c_t32 > bpc_pkg::TEMP_MAX)
            c_side_next.t = bpc_pkg::TEMP_MAX[bpc_pkg::TEMP_W-1:0];
        else
            c_side_next.t = c_t32[bpc_pkg::TEMP_W-1:0];
        c_side_next.err = td_last.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (pipe_en)
            c_v_reg <= td_v_reg[bpc_pkg::TDIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            c_b6_reg   <= c_b5 - bpc_pkg::TEMP_OFFSET;
            c_side_reg <= c_side_next;
            c_up_reg   <= td_last.up;
        end
    end

    // stage d: b6 squared and the ac2, ac3 products
    logic signed [63:0] d_sq_full, d_a2_full, d_a3_full;
    logic               d_v_reg;
    logic signed [31:0] d_sq_reg, d_a2_reg, d_a3_reg;
    bpc_pkg::side_t     d_side_reg;
    logic [bpc_pkg::RAW_P_W-1:0] d_up_reg;

    assign d_sq_full = c_b6_reg * c_b6_reg;
    assign d_a2_full = ac2 * c_b6_reg;
    assign d_a3_full = ac3 * c_b6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else if (pipe_en)
            d_v_reg <= c_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            d_sq_reg   <= $signed(d_sq_full[31:0]) >>> 12;
            d_a2_reg   <= $signed(d_a2_full[31:0]) >>> 11;
            d_a3_reg   <= $signed(d_a3_full[31:0]) >>> 13;
            d_side_reg <= c_side_reg;
            d_up_reg   <= c_up_reg;
        end
    end

    // stage e: b2 and b1 products of the square
    logic signed [63:0] e_b2_full, e_b1_full;
    logic               e_v_reg;
    logic signed [31:0] e_b2_reg, e_b1_reg, e_a2_reg, e_a3_reg;
    bpc_pkg::side_t     e_side_reg;
    logic [bpc_pkg::RAW_P_W-1:0] e_up_reg;

    assign e_b2_full = b2 * d_sq_reg;
    assign e_b1_full = b1 * d_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_v_reg <= 1'b0;
        else if (pipe_en)
            e_v_reg <= d_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            e_b2_reg   <= $signed(e_b2_full[31:0]) >>> 11;
            e_b1_reg   <= $signed(e_b1_full[31:0]) >>> 16;
            e_a2_reg   <= d_a2_reg;
            e_a3_reg   <= d_a3_reg;
            e_side_reg <= d_side_reg;
            e_up_reg   <= d_up_reg;
        end
    end

    // stage f: b3 and the b4 multiplicand
    logic signed [31:0] f_b3_base, f_b3_sh, f_x3p;
    logic               f_v_reg;
    logic signed [31:0] f_b3_reg;
    logic        [31:0] f_b4pre_reg;
    bpc_pkg::side_t     f_side_reg;
    logic [bpc_pkg::RAW_P_W-1:0] f_up_reg;

    assign f_b3_base = $signed({{14{ac1[15]}}, ac1, 2'b00}) + e_b2_reg + e_a2_reg;
    assign f_b3_sh   = f_b3_base <<< oss_reg;
    assign f_x3p     = (e_a3_reg + e_b1_reg + 32'sd2) >>> 2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_v_reg <= 1'b0;
        else if (pipe_en)
            f_v_reg <= e_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            f_b3_reg    <= (f_b3_sh + 32'sd2) >>> 2;
            f_b4pre_reg <= 32'(f_x3p + bpc_pkg::B4_BIAS);
            f_side_reg  <= e_side_reg;
            f_up_reg    <= e_up_reg;
        end
    end

    // stage g: b4 and the pressure difference
    logic [47:0] g_b4_full;
    logic        g_v_reg;
    logic [16:0] g_b4_reg;
    logic [31:0] g_diff_reg;
    bpc_pkg::side_t g_side_reg;

    assign g_b4_full = ac4 * f_b4pre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_v_reg <= 1'b0;
        else if (pipe_en)
            g_v_reg <= f_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            g_b4_reg   <= g_b4_full[31:15];
            g_diff_reg <= {13'd0, f_up_reg} - 32'(f_b3_reg);
            g_side_reg <= f_side_reg;
        end
    end

    // pressure divider setup: b7 and the dividend
    logic [15:0]    pd_scale;
    logic [47:0]    pd_b7_full;
    logic [31:0]    pd_b7;
    bpc_pkg::pdiv_t pd_first;

    assign pd_scale   = bpc_pkg::B7_SCALE >> oss_reg;
    assign pd_b7_full = g_diff_reg * pd_scale;
    assign pd_b7      = pd_b7_full[31:0];

    always_comb
    begin
        pd_first.rem      = '0;
        pd_first.hi       = pd_b7[31];
        pd_first.num      = pd_b7[31] ? pd_b7 : {pd_b7[30:0], 1'b0};
        pd_first.den      = g_b4_reg;
        pd_first.side.t   = g_side_reg.t;
        pd_first.side.err = g_side_reg.err | (g_b4_reg == 17'd0);
    end

    function automatic bpc_pkg::pdiv_t pdiv_step(input bpc_pkg::pdiv_t s);
        bpc_pkg::pdiv_t r;
        logic [17:0]    sh;
        logic           q;
        r  = s;
        sh = {s.rem, s.num[bpc_pkg::PDIV_STEPS-1]};
        q  = (sh >= {1'b0, s.den});
        r.rem = q ? 17'(sh - {1'b0, s.den}) : sh[16:0];
        r.num = {s.num[bpc_pkg::PDIV_STEPS-2:0], q};
        return r;
    endfunction

    bpc_pkg::pdiv_t               pd_reg [0:bpc_pkg::PDIV_STEPS];
    logic [bpc_pkg::PDIV_STEPS:0] pd_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pd_v_reg <= '0;
        else if (pipe_en)
            pd_v_reg <= {pd_v_reg[bpc_pkg::PDIV_STEPS-1:0], g_v_reg};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            pd_reg[0] <= pd_first;
    end

    for (genvar k = 0; k < bpc_pkg::PDIV_STEPS; k++)
    begin : g_pdiv
        always_ff @(posedge clk)
        begin
            if (pipe_en)
                pd_reg[k+1] <= pdiv_step(pd_reg[k]);
        end
    end

    // stage j: raw pressure and its scaled copy
    bpc_pkg::pdiv_t     pd_last;
    logic signed [31:0] j_p_next;
    logic               j_v_reg;
    logic signed [31:0] j_p_reg, j_c1_reg;
    bpc_pkg::side_t     j_side_reg;

    assign pd_last  = pd_reg[bpc_pkg::PDIV_STEPS];
    assign j_p_next = pd_last.hi ? $signed({pd_last.num[30:0], 1'b0}) : $signed(pd_last.num);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_v_reg <= 1'b0;
        else if (pipe_en)
            j_v_reg <= pd_v_reg[bpc_pkg::PDIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            j_p_reg    <= j_p_next;
            j_c1_reg   <= j_p_next >>> 8;
            j_side_reg <= pd_last.side;
        end
    end

    // stage k: square term and linear correction term
    logic signed [63:0] k_sq_full, k_lin_full;
    logic               k_v_reg;
    logic signed [31:0] k_sq_reg, k_x2_reg, k_p_reg;
    bpc_pkg::side_t     k_side_reg;

    assign k_sq_full  = j_c1_reg * j_c1_reg;
    assign k_lin_full = bpc_pkg::CORR_LIN * j_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_v_reg <= 1'b0;
        else if (pipe_en)
            k_v_reg <= j_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            k_sq_reg   <= $signed(k_sq_full[31:0]);
            k_x2_reg   <= $signed(k_lin_full[31:0]) >>> 16;
            k_p_reg    <= j_p_reg;
            k_side_reg <= j_side_reg;
        end
    end

    // stage l: scaled square term
    logic signed [63:0] l_x1_full;
    logic               l_v_reg;
    logic signed [31:0] l_x1_reg, l_x2_reg, l_p_reg;
    bpc_pkg::side_t     l_side_reg;

    assign l_x1_full = k_sq_reg * bpc_pkg::CORR_SQ;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l_v_reg <= 1'b0;
        else if (pipe_en)
            l_v_reg <= k_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            l_x1_reg   <= $signed(l_x1_full[31:0]) >>> 16;
            l_x2_reg   <= k_x2_reg;
            l_p_reg    <= k_p_reg;
            l_side_reg <= k_side_reg;
        end
    end

    // final correction, saturation and error forcing
    logic signed [31:0]                  m_pf;
    logic signed [bpc_pkg::TEMP_W-1:0]   m_t;
    logic        [bpc_pkg::PRESS_W-1:0]  m_p;

    assign m_pf = l_p_reg + ((l_x1_reg + l_x2_reg + bpc_pkg::CORR_OFF) >>> 4);

    always_comb
    begin
        if (l_side_reg.err)
        begin
            m_t = '0;
            m_p = '0;
        end
        else
        begin
            m_t = l_side_reg.t;
            if (m_pf < 32'sd0)
                m_p = '0;
            else if (m_pf > bpc_pkg::PRESS_MAX)
                m_p = bpc_pkg::PRESS_MAX[bpc_pkg::PRESS_W-1:0];
            else
                m_p = m_pf[bpc_pkg::PRESS_W-1:0];
        end
    end

    // output register and skid register
    logic                                out_v_reg;
    logic signed [bpc_pkg::TEMP_W-1:0]   out_t_reg, skid_t_reg;
    logic        [bpc_pkg::PRESS_W-1:0]  out_p_reg, skid_p_reg;
    logic                                out_e_reg, skid_e_reg;
    logic                                push;

    assign push = pipe_en & l_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || out_ch.ready)
        begin
            out_v_reg  <= skid_v_reg | push;
            skid_v_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || out_ch.ready)
        begin
            if (skid_v_reg)
            begin
                out_t_reg <= skid_t_reg;
                out_p_reg <= skid_p_reg;
                out_e_reg <= skid_e_reg;
            end
            else if (push)
            begin
                out_t_reg <= m_t;
                out_p_reg <= m_p;
                out_e_reg <= l_side_reg.err;
            end
        end
        else if (push)
        begin
            skid_t_reg <= m_t;
            skid_p_reg <= m_p;
            skid_e_reg <= l_side_reg.err;
        end
    end

    assign out_ch.valid              = out_v_reg;
    assign out_ch.temperature_tenths = out_t_reg;
    assign out_ch.pressure_pa        = out_p_reg;
    assign out_ch.div_error          = out_e_reg;

endmodule
